### rtl/core/rhfg_pkg.sv
// Shared types and constants for the RGB hue fade generator.
package rhfg_pkg;

  localparam int unsigned COLOR_W    = 8;
  localparam int unsigned HUE_W      = 10;
  localparam int unsigned SPEED_W    = 2;
  localparam int unsigned DIV_W      = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned MUL_A_W    = 9;
  localparam int unsigned MUL_P_W    = MUL_A_W + COLOR_W;

  localparam logic [HUE_W-1:0]   HUE_LAST       = 10'd767;
  localparam logic [COLOR_W-1:0] BRIGHTNESS_RST = 8'd16;
  localparam logic [COLOR_W-1:0] SATURATION_RST = 8'd255;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FADE_SPEED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SATURATION = 2'd2;

  // Hue sectors
  localparam logic [1:0] SECTOR_0 = 2'd0;
  localparam logic [1:0] SECTOR_1 = 2'd1;
  localparam logic [1:0] SECTOR_2 = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_RAMP  = 5'b00010,
    ST_SCALE = 5'b00100,
    ST_FLOOR = 5'b01000,
    ST_LOAD  = 5'b10000
  } rhfg_state_t;

endpackage

### rtl/core/rgb_hue_fade_generator_top.sv
// Top level of the RGB hue fade generator: tick divider, hue counter, shared-multiplier HSB-to-RGB.
//
// Each accepted tick request either just bumps the tick divider or, on every
// fade_speed+1-th tick, starts a color conversion. A conversion runs three passes through one
// shared 9x8 multiplier (ramp times saturation, that times brightness, floor level times
// brightness) and then loads the output register, so a color-producing tick holds the input
// stalled in RAMP, SCALE, FLOOR and LOAD, plus while the output side stalls a previous color.
// fade_speed 0 disables fading: ticks are accepted and change nothing. There is no clearing pass.
module rgb_hue_fade_generator_top
  import rhfg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_tick,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [COLOR_W-1:0]    out_red,
  output logic [COLOR_W-1:0]    out_green,
  output logic [COLOR_W-1:0]    out_blue,
  output logic [HUE_W-1:0]      out_hue_used
);

  rhfg_state_t          state_r, state_nxt;
  logic [SPEED_W-1:0]   speed_r;
  logic [COLOR_W-1:0]   bri_r;
  logic [COLOR_W-1:0]   sat_r;
  logic [DIV_W-1:0]     div_r, div_nxt;
  logic [HUE_W-1:0]     hue_r, hue_nxt;
  logic [HUE_W-1:0]     conv_hue_r;
  logic [COLOR_W-1:0]   ramp_r, x_r, s_r;
  logic                 out_valid_r, out_valid_nxt;
  logic [COLOR_W-1:0]   red_r, green_r, blue_r;
  logic [HUE_W-1:0]     hue_used_r;

  logic                 in_acc;
  logic                 tick_go;
  logic [DIV_W-1:0]     div_inc;
  logic                 emit;
  logic [MUL_A_W-1:0]   mul_a;
  logic [COLOR_W-1:0]   mul_b;
  logic [MUL_P_W-1:0]   mul_p;
  logic [COLOR_W-1:0]   mul_hi;
  logic                 load_en;
  logic [COLOR_W-1:0]   lvl_lo, lvl_mid, lvl_hi;
  logic [COLOR_W-1:0]   red_nxt, green_nxt, blue_nxt;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign tick_go  = in_acc && in_tick && (speed_r != '0);
  assign div_inc  = div_r + DIV_W'(1);
  assign emit     = tick_go && (div_inc > DIV_W'(speed_r));

  // Shared multiplier; operands chosen by the sequencer state
  always_comb begin
    mul_a = '0;
    mul_b = bri_r;
    unique case (state_r)
      ST_RAMP: begin
        mul_a = {1'b0, conv_hue_r[COLOR_W-1:0]};
        mul_b = sat_r;
      end
      ST_SCALE: begin
        mul_a = {1'b0, ramp_r};
      end
      ST_FLOOR: begin
        // 256 - saturation, nine bits wide
        mul_a = {1'b1, {COLOR_W{1'b0}}} - {1'b0, sat_r};
      end
      ST_IDLE, ST_LOAD: begin
        mul_a = '0;
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  assign mul_p  = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
  assign mul_hi = mul_p[2*COLOR_W-1:COLOR_W];

  // Color levels: floor, ramp up, ramp down
  assign lvl_lo  = s_r;
  assign lvl_mid = x_r + s_r;
  assign lvl_hi  = bri_r - x_r;

  always_comb begin
    case (conv_hue_r[HUE_W-1:COLOR_W])
      SECTOR_1: begin
        red_nxt   = lvl_lo;
        green_nxt = lvl_hi;
        blue_nxt  = lvl_mid;
      end
      SECTOR_2: begin
        red_nxt   = lvl_mid;
        green_nxt = lvl_lo;
        blue_nxt  = lvl_hi;
      end
      default: begin
        red_nxt   = lvl_hi;
        green_nxt = lvl_mid;
        blue_nxt  = lvl_lo;
      end
    endcase
  end

  assign load_en = (state_r == ST_LOAD) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    div_nxt   = div_r;
    hue_nxt   = hue_r;
    unique case (state_r)
      ST_IDLE: begin
        if (tick_go) begin
          if (emit) begin
            div_nxt   = '0;
            hue_nxt   = (hue_r == HUE_LAST) ? '0 : hue_r + HUE_W'(1);
            state_nxt = ST_RAMP;
          end else begin
            div_nxt = div_inc;
          end
        end
      end
      ST_RAMP:  state_nxt = ST_SCALE;
      ST_SCALE: state_nxt = ST_FLOOR;
      ST_FLOOR: state_nxt = ST_LOAD;
      ST_LOAD: begin
        if (load_en) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (load_en) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      speed_r     <= '0;
      bri_r       <= BRIGHTNESS_RST;
      sat_r       <= SATURATION_RST;
      div_r       <= '0;
      hue_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      div_r       <= div_nxt;
      hue_r       <= hue_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_FADE_SPEED: speed_r <= cfg_wdata[SPEED_W-1:0];
          REG_BRIGHTNESS: bri_r   <= cfg_wdata[COLOR_W-1:0];
          REG_SATURATION: sat_r   <= cfg_wdata[COLOR_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && emit) begin
      conv_hue_r <= hue_r;
    end
    if (state_r == ST_RAMP) begin
      ramp_r <= mul_hi;
    end
    if (state_r == ST_SCALE) begin
      x_r <= mul_hi;
    end
    if (state_r == ST_FLOOR) begin
      s_r <= mul_hi;
    end
    if (load_en) begin
      red_r      <= red_nxt;
      green_r    <= green_nxt;
      blue_r     <= blue_nxt;
      hue_used_r <= conv_hue_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_red      = red_r;
  assign out_green    = green_r;
  assign out_blue     = blue_r;
  assign out_hue_used = hue_used_r;

endmodule
